// ===== hw/rtl/spqs_pkg.sv =====
// ============================================================================
// spqs_pkg: strict priority queue scheduler package
// Sizes, request codes and the request record passed from the front end to
// the queue engine.
// ============================================================================
package spqs_pkg;

    localparam int N_QUEUES    = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int ELEM_WIDTH  = 32;

    localparam int QUEUE_W = $clog2(N_QUEUES);
    localparam int POS_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = $clog2(N_QUEUES * QUEUE_DEPTH);
    localparam int CFG_W   = 4;

    // stream packing
    localparam int S_DATA_W = 8 * ((QUEUE_W + ELEM_WIDTH + 7) / 8);
    localparam int M_DATA_W = 8 * ((ELEM_WIDTH + QUEUE_W + 7) / 8);

    // command queue between front end and engine
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // request kinds
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [QUEUE_W-1:0]    queue;
        logic [ELEM_WIDTH-1:0] element;
    } t_req;

endpackage

// ===== hw/rtl/spqs_front.sv =====
// ============================================================================
// spqs_front: request front end
// Takes request beats, sorts them into enqueue / dequeue records and holds
// them in a short command queue for the engine.
// ============================================================================
module spqs_front
    import spqs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_beat_valid,
    output logic                o_beat_ready,
    input  logic                i_beat_kind,
    input  logic [S_DATA_W-1:0] i_beat_data,
    output logic                o_cmd_valid,
    output t_req                o_cmd,
    input  logic                i_cmd_pop
);

    t_req                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    t_req                  n_req;
    logic                  push;
    logic                  pop;

    always_comb begin
        n_req.op      = (i_beat_kind == OP_DEQ) ? OP_DEQ : OP_ENQ;
        n_req.queue   = i_beat_data[QUEUE_W-1:0];
        n_req.element = i_beat_data[QUEUE_W +: ELEM_WIDTH];
    end

    assign o_beat_ready = (r_count != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push         = i_beat_valid && o_beat_ready;
    assign o_cmd_valid  = (r_count != '0);
    assign pop          = i_cmd_pop && o_cmd_valid;
    assign o_cmd        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/spqs_engine.sv =====
// ============================================================================
// spqs_engine: queue engine
// Holds the element store, head pointers and fill counts; executes enqueue
// and dequeue commands and drives the result register.
// ============================================================================
module spqs_engine
    import spqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_W-1:0]      i_queues_in_use,
    input  logic                  i_cmd_valid,
    input  t_req                  i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_res_found,
    output logic [ELEM_WIDTH-1:0] o_res_element,
    output logic [QUEUE_W-1:0]    o_res_queue
);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic [ELEM_WIDTH-1:0] r_mem [N_QUEUES * QUEUE_DEPTH];
    logic [ELEM_WIDTH-1:0] r_rd_data;

    logic [POS_W-1:0]      r_head [N_QUEUES];
    logic [FILL_W-1:0]     r_fill [N_QUEUES];

    logic                  r_state, n_state;
    logic [QUEUE_W-1:0]    r_rd_queue;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [ELEM_WIDTH-1:0] r_out_element;
    logic [QUEUE_W-1:0]    r_out_queue;

    logic [CFG_W-1:0]      active;
    logic                  out_free;
    logic                  do_enq, do_deq;
    logic                  enq_ok;
    logic                  sel_found;
    logic [QUEUE_W-1:0]    sel_queue;
    logic [POS_W:0]        tail_sum;
    logic [POS_W-1:0]      tail_pos;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    assign active   = (i_queues_in_use > CFG_W'(N_QUEUES)) ? CFG_W'(N_QUEUES)
                                                            : i_queues_in_use;
    assign out_free = !r_out_valid || i_res_ready;

    assign o_cmd_pop = (r_state == ST_RUN) && i_cmd_valid &&
                       ((i_cmd.op == OP_ENQ) || out_free);
    assign do_enq    = o_cmd_pop && (i_cmd.op == OP_ENQ);
    assign do_deq    = o_cmd_pop && (i_cmd.op == OP_DEQ);

    // lowest numbered active, non-empty queue
    always_comb begin
        sel_found = 1'b0;
        sel_queue = '0;
        for (int i = N_QUEUES - 1; i >= 0; i--) begin
            if ((r_fill[i] != '0) && (CFG_W'(i) < active)) begin
                sel_found = 1'b1;
                sel_queue = QUEUE_W'(i);
            end
        end
    end

    // tail position, wrapped
    always_comb begin
        tail_sum = {1'b0, r_head[i_cmd.queue]} + (POS_W+1)'(r_fill[i_cmd.queue]);
        if (tail_sum >= (POS_W+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (POS_W+1)'(QUEUE_DEPTH);
        end
        tail_pos = tail_sum[POS_W-1:0];
    end

    assign enq_ok  = ({1'b0, i_cmd.queue} < active) &&
                     (r_fill[i_cmd.queue] < FILL_W'(QUEUE_DEPTH));
    assign wr_addr = ADDR_W'(i_cmd.queue) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
    assign rd_addr = ADDR_W'(sel_queue) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[sel_queue]);

    always_ff @(posedge i_clk) begin
        if (do_enq && enq_ok) begin
            r_mem[wr_addr] <= i_cmd.element;
        end
        if (do_deq && sel_found) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (do_deq && sel_found) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
            for (int i = 0; i < N_QUEUES; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (do_enq && enq_ok) begin
                r_fill[i_cmd.queue] <= r_fill[i_cmd.queue] + 1'b1;
            end
            if (do_deq && sel_found) begin
                r_fill[sel_queue] <= r_fill[sel_queue] - 1'b1;
                r_head[sel_queue] <= (r_head[sel_queue] == POS_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : r_head[sel_queue] + 1'b1;
            end
            if ((do_deq && !sel_found) || (r_state == ST_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_deq) begin
            r_rd_queue <= sel_queue;
        end
        if (do_deq && !sel_found) begin
            r_out_found   <= 1'b0;
            r_out_element <= '0;
            r_out_queue   <= '0;
        end else if (r_state == ST_READ) begin
            r_out_found   <= 1'b1;
            r_out_element <= r_rd_data;
            r_out_queue   <= r_rd_queue;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_res_found   = r_out_found;
    assign o_res_element = r_out_element;
    assign o_res_queue   = r_out_queue;

endmodule

// ===== hw/rtl/strict_priority_queue_scheduler_core.sv =====
// ============================================================================
// strict_priority_queue_scheduler_core: strict priority multi-queue scheduler
// Eight bounded FIFO queues of 32-bit handles; dequeue serves the lowest
// numbered active non-empty queue.
// ============================================================================
// Usage
//   s_axis: request beats. tuser = request kind (0 enqueue, 1 dequeue).
//     tdata = target queue, element. Enqueues to a full or inactive queue
//     are dropped; enqueues never give a result beat.
//   m_axis: one result beat per dequeue. tuser = found flag. tdata =
//     element, served queue (both zero when every active queue is empty).
//   cfg: i_cfg_data[3:0] = queues in use (reset 8, saturated at 8). Write
//     only while the block is idle; o_cfg_ready is always high.
// Timing
//   Requests land in a two-beat command queue; the engine takes one per cycle
//   outside its read state, a dequeue also waiting for a free result register.
//   A dequeue that finds an element passes the read state, as the element
//   store has a registered read port. A found element passes the command queue,
//   store read and result registers; a not-found result skips the store read.
// Reset
//   Synchronous, active low. All queues become empty; the store itself is
//   not cleared and needs no clearing pass.
// Back-pressure
//   A stalled m_axis holds its result register; the next dequeue waits at
//   the head of the command queue, which then fills and drops s_axis_tready.
// ============================================================================
module strict_priority_queue_scheduler_core
    import spqs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,      // queues_in_use
    // request stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,    // [2:0] target_queue, [34:3] element
    input  logic [0:0]          s_axis_tuser,    // [0] req_type
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,    // [31:0] out_element, [34:32] served_queue
    output logic [0:0]          m_axis_tuser     // [0] found
);

    logic [CFG_W-1:0]      r_queues_in_use;

    logic                  cmd_valid;
    t_req                  cmd;
    logic                  cmd_pop;

    logic                  res_found;
    logic [ELEM_WIDTH-1:0] res_element;
    logic [QUEUE_W-1:0]    res_queue;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queues_in_use <= CFG_W'(8);
        end else if (i_cfg_valid) begin
            r_queues_in_use <= i_cfg_data;
        end
    end

    // front end: accept and sort requests
    spqs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (s_axis_tvalid),
        .o_beat_ready (s_axis_tready),
        .i_beat_kind  (s_axis_tuser[0]),
        .i_beat_data  (s_axis_tdata),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // back end: queue store and priority select
    spqs_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_queues_in_use (r_queues_in_use),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_res_found     (res_found),
        .o_res_element   (res_element),
        .o_res_queue     (res_queue)
    );

    // result packing, upper pad bits zero
    always_comb begin
        m_axis_tdata                         = '0;
        m_axis_tdata[ELEM_WIDTH-1:0]         = res_element;
        m_axis_tdata[ELEM_WIDTH +: QUEUE_W]  = res_queue;
        m_axis_tuser[0]                      = res_found;
    end

endmodule
